// ===== design/crsi_pkg.sv =====
// Shared package of the Catmull-Rom series interpolator.
// Holds widths, status and mode codes, and the controller-datapath types.
// No dependencies.
package crsi_pkg;

  // Default table depth
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VAL_W   = 17;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ENTRY_W = TIME_W + 2 * VAL_W;

  // Fixed-point arithmetic
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned T_W     = FRAC_W + 1;       // t spans 0..1.0 inclusive
  localparam int unsigned H_W     = 24;               // Horner accumulator
  localparam int unsigned PROD_W  = H_W + T_W + 1;
  localparam int          Q_ONE   = 65536;

  // Divider sequencing
  localparam int unsigned DIV_STEPS = T_W;
  localparam int unsigned STEP_W    = 5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INTERP  = 3'd0;
  localparam logic [STAT_W-1:0] ST_OUTSIDE = 3'd1;
  localparam logic [STAT_W-1:0] ST_TOOFEW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_STORED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd5;

  // Request mode codes; mode bit 1 selects a query
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
  localparam int unsigned       MODE_QUERY_BIT = 1;

  // One table entry
  typedef struct packed {
    logic [TIME_W-1:0] tstamp;
    logic [VAL_W-1:0]  val_a;
    logic [VAL_W-1:0]  val_b;
  } entry_t;

  // Table read address source
  typedef enum logic [2:0] {
    RD_ZERO,
    RD_LAST,
    RD_K,
    RD_KP1,
    RD_KM2
  } rd_sel_e;

  // Index register operation
  typedef enum logic [2:0] {
    K_HOLD,
    K_LOAD_N,
    K_SET_ONE,
    K_INC,
    K_DEC
  } k_op_e;

  // Spline lane operation
  typedef enum logic [1:0] {
    LANE_HOLD,
    LANE_INIT,
    LANE_MUL,
    LANE_ADD
  } lane_op_e;

  // Horner coefficient select
  typedef enum logic [1:0] {
    COEF_C2,
    COEF_C1,
    COEF_C0
  } coef_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              latch;
    logic              cnt_clr;
    logic              cnt_inc;
    k_op_e             k_op;
    rd_sel_e           rd_sel;
    logic              wr_en;
    logic              wr_new;
    logic              win_init;
    logic              win_shift;
    logic              cap_seg;
    logic              cap_p3;
    logic              div_step;
    lane_op_e          lane_op;
    coef_sel_e         coef_sel;
    logic              fin;
    logic [STAT_W-1:0] fin_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cnt_full;
    logic              cnt_zero;
    logic              cnt_lt2;
    logic              k_one;
    logic              k_last;
    logic              rd_gt;
    logic              rd_lt;
  } stat_t;

endpackage

// ===== design/crsi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crsi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/crsi_cubic.sv =====
// One spline lane: Catmull-Rom coefficients, Horner evaluation, clamp.
// Depends on crsi_pkg.
module crsi_cubic (
  input  logic                      clk_i,
  input  crsi_pkg::lane_op_e        op_i,
  input  crsi_pkg::coef_sel_e       coef_sel_i,
  input  logic [crsi_pkg::VAL_W-1:0] p0_i,
  input  logic [crsi_pkg::VAL_W-1:0] p1_i,
  input  logic [crsi_pkg::VAL_W-1:0] p2_i,
  input  logic [crsi_pkg::VAL_W-1:0] p3_i,
  input  logic [crsi_pkg::T_W-1:0]   t_i,
  output logic [crsi_pkg::VAL_W-1:0] res_o
);

  localparam int unsigned HW = crsi_pkg::H_W;
  localparam int unsigned PW = crsi_pkg::PROD_W;
  localparam int unsigned EXT = HW - crsi_pkg::VAL_W;
  localparam logic signed [HW-1:0] ONE_S = HW'(crsi_pkg::Q_ONE);
  localparam logic signed [HW-1:0] RND_S = HW'(1);

  logic signed [HW-1:0] p0s, p1s, p2s, p3s;
  logic signed [HW-1:0] c0, c1, c2, c3, coef;
  logic signed [HW-1:0] h_q, h_d;
  logic signed [PW-1:0] prod_q, prod_d, shr;
  logic signed [crsi_pkg::T_W:0] t_s;
  logic signed [HW-1:0] rnd;

  // Coefficients from the four control points
  assign p0s = $signed({{EXT{1'b0}}, p0_i});
  assign p1s = $signed({{EXT{1'b0}}, p1_i});
  assign p2s = $signed({{EXT{1'b0}}, p2_i});
  assign p3s = $signed({{EXT{1'b0}}, p3_i});
  assign c0  = p1s + p1s;
  assign c1  = p2s - p0s;
  assign c2  = (p0s <<< 1) - ((p1s <<< 2) + p1s) + (p2s <<< 2) - p3s;
  assign c3  = p3s - p0s + ((p1s <<< 1) + p1s) - ((p2s <<< 1) + p2s);

  always_comb begin
    unique case (coef_sel_i)
      crsi_pkg::COEF_C2: coef = c2;
      crsi_pkg::COEF_C1: coef = c1;
      crsi_pkg::COEF_C0: coef = c0;
      default:           coef = c0;
    endcase
  end

  // Horner step: multiply, then floor-shift and add
  assign t_s    = $signed({1'b0, t_i});
  assign prod_d = h_q * t_s;
  assign shr    = prod_q >>> crsi_pkg::FRAC_W;

  always_comb begin
    unique case (op_i)
      crsi_pkg::LANE_INIT: h_d = c3;
      crsi_pkg::LANE_ADD:  h_d = $signed(shr[HW-1:0]) + coef;
      default:             h_d = h_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (op_i == crsi_pkg::LANE_MUL) begin
      prod_q <= prod_d;
    end
  end

  // Halve with rounding, clamp to 0..1.0
  assign rnd = (h_q + RND_S) >>> 1;

  always_comb begin
    priority if (rnd < 0) begin
      res_o = '0;
    end else if (rnd > ONE_S) begin
      res_o = ONE_S[crsi_pkg::VAL_W-1:0];
    end else begin
      res_o = rnd[crsi_pkg::VAL_W-1:0];
    end
  end

endmodule

// ===== design/crsi_ctrl.sv =====
// Controller state machine of the Catmull-Rom series interpolator.
// Sequences clear, sorted insert, segment search, division and spline steps.
// Depends on crsi_pkg.
module crsi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  crsi_pkg::stat_t  stat_i,
  output crsi_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_L_CMP,
    S_L_WNEW,
    S_Q_FIRST,
    S_Q_LAST,
    S_Q_SRD,
    S_Q_SCMP,
    S_Q_P3,
    S_DIV,
    S_SP_INIT,
    S_SP_MUL,
    S_SP_ADD,
    S_FIN
  } state_e;

  localparam logic [crsi_pkg::STEP_W-1:0] DIV_LAST = crsi_pkg::STEP_W'(crsi_pkg::DIV_STEPS - 1);
  localparam logic [crsi_pkg::STEP_W-1:0] SP_LAST  = crsi_pkg::STEP_W'(2);

  state_e                      state_q, state_d;
  logic [crsi_pkg::STEP_W-1:0] step_q, step_d;
  logic                        done_q;
  crsi_pkg::cmd_t              cmd;

  // Next state and command decode
  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cmd            = '0;
    cmd.k_op       = crsi_pkg::K_HOLD;
    cmd.rd_sel     = crsi_pkg::RD_ZERO;
    cmd.lane_op    = crsi_pkg::LANE_HOLD;
    cmd.coef_sel   = crsi_pkg::COEF_C0;
    cmd.fin_status = crsi_pkg::ST_INTERP;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.latch = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        priority if (stat_i.mode[crsi_pkg::MODE_QUERY_BIT]) begin
          if (stat_i.cnt_lt2) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = crsi_pkg::ST_TOOFEW;
          end else begin
            cmd.rd_sel = crsi_pkg::RD_ZERO;
            state_d    = S_Q_FIRST;
          end
        end else if (stat_i.mode == crsi_pkg::MODE_LOAD) begin
          if (stat_i.cnt_full) begin
            cmd.fin        = 1'b1;
            cmd.fin_status = crsi_pkg::ST_FULL;
          end else begin
            cmd.k_op   = crsi_pkg::K_LOAD_N;
            cmd.rd_sel = crsi_pkg::RD_LAST;
            state_d    = stat_i.cnt_zero ? S_L_WNEW : S_L_CMP;
          end
        end else begin
          cmd.cnt_clr    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = crsi_pkg::ST_CLEARED;
        end
      end
      // Entry k-1 is on the read port; move it up or drop the new point at k
      S_L_CMP: begin
        cmd.wr_en = 1'b1;
        if (stat_i.rd_gt) begin
          cmd.k_op   = crsi_pkg::K_DEC;
          cmd.rd_sel = crsi_pkg::RD_KM2;
          if (stat_i.k_one) begin
            state_d = S_L_WNEW;
          end
        end else begin
          cmd.wr_new     = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.fin        = 1'b1;
          cmd.fin_status = crsi_pkg::ST_STORED;
        end
      end
      S_L_WNEW: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_new     = 1'b1;
        cmd.cnt_inc    = 1'b1;
        cmd.fin        = 1'b1;
        cmd.fin_status = crsi_pkg::ST_STORED;
      end
      S_Q_FIRST: begin
        if (stat_i.rd_gt) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = crsi_pkg::ST_OUTSIDE;
        end else begin
          cmd.win_init = 1'b1;
          cmd.rd_sel   = crsi_pkg::RD_LAST;
          state_d      = S_Q_LAST;
        end
      end
      S_Q_LAST: begin
        if (stat_i.rd_lt) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = crsi_pkg::ST_OUTSIDE;
        end else begin
          cmd.k_op = crsi_pkg::K_SET_ONE;
          state_d  = S_Q_SRD;
        end
      end
      S_Q_SRD: begin
        cmd.rd_sel = crsi_pkg::RD_K;
        state_d    = S_Q_SCMP;
      end
      // Scan for the first upper end at or past the query time
      S_Q_SCMP: begin
        cmd.rd_sel = crsi_pkg::RD_KP1;
        if (!stat_i.rd_lt || stat_i.k_last) begin
          cmd.cap_seg = 1'b1;
          step_d      = '0;
          state_d     = stat_i.k_last ? S_DIV : S_Q_P3;
        end else begin
          cmd.win_shift = 1'b1;
          cmd.k_op      = crsi_pkg::K_INC;
        end
      end
      S_Q_P3: begin
        cmd.cap_p3 = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_d       = step_q + 1'b1;
        if (step_q == DIV_LAST) begin
          state_d = S_SP_INIT;
        end
      end
      S_SP_INIT: begin
        cmd.lane_op = crsi_pkg::LANE_INIT;
        step_d      = '0;
        state_d     = S_SP_MUL;
      end
      S_SP_MUL: begin
        cmd.lane_op = crsi_pkg::LANE_MUL;
        state_d     = S_SP_ADD;
      end
      S_SP_ADD: begin
        cmd.lane_op = crsi_pkg::LANE_ADD;
        priority case (step_q)
          '0:           cmd.coef_sel = crsi_pkg::COEF_C2;
          1:            cmd.coef_sel = crsi_pkg::COEF_C1;
          default:      cmd.coef_sel = crsi_pkg::COEF_C0;
        endcase
        step_d  = step_q + 1'b1;
        state_d = (step_q == SP_LAST) ? S_FIN : S_SP_MUL;
      end
      S_FIN: begin
        cmd.fin        = 1'b1;
        cmd.fin_status = crsi_pkg::ST_INTERP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cmd.fin) begin
      state_d = S_IDLE;
    end
  end

  // State and registered strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= cmd.fin;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  // A result strobe always comes back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  // An accepted request is decoded next cycle
  a_accept_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> state_q == S_DEC)
    else $error("accepted request not decoded");

  // Divider never runs past its quotient width
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q <= DIV_LAST)
    else $error("divider step out of range");

endmodule

// ===== design/crsi_dp.sv =====
// Datapath of the Catmull-Rom series interpolator: point table, index,
// segment window, bit-serial divider, two spline lanes and result registers.
// Depends on crsi_pkg, crsi_ram and crsi_cubic.
module crsi_dp #(
  parameter int unsigned MAX_POINTS = crsi_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crsi_pkg::cmd_t              cmd_i,
  output crsi_pkg::stat_t             stat_o,
  input  logic [crsi_pkg::MODE_W-1:0] mode_i,
  input  logic [crsi_pkg::TIME_W-1:0] time_stamp_i,
  input  logic [crsi_pkg::VAL_W-1:0]  value_a_i,
  input  logic [crsi_pkg::VAL_W-1:0]  value_b_i,
  output logic [crsi_pkg::STAT_W-1:0] status_o,
  output logic [crsi_pkg::TIME_W-1:0] echo_time_o,
  output logic [crsi_pkg::VAL_W-1:0]  result_a_o,
  output logic [crsi_pkg::VAL_W-1:0]  result_b_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned TW = crsi_pkg::TIME_W;
  localparam int unsigned QW = crsi_pkg::T_W;

  // Latched request
  logic [crsi_pkg::MODE_W-1:0] mode_q;
  logic [TW-1:0]               ts_q;
  logic [crsi_pkg::VAL_W-1:0]  va_q, vb_q;

  // Table control
  logic [CW-1:0]   cnt_q, k_q, k_d, last_idx, rd_idx;
  logic [AW-1:0]   raddr;
  crsi_pkg::entry_t rd_e, wr_e, new_e;

  // Segment window and divider
  crsi_pkg::entry_t prev2_q, prev_q, cur_q, p3_q;
  logic [TW-1:0]   span;
  logic [TW:0]     rem_q, rem_sub;
  logic [QW-1:0]   quo_q, t_val;
  logic            q_bit;

  // Result registers
  logic [crsi_pkg::STAT_W-1:0] status_q;
  logic [TW-1:0]               echo_q;
  logic [crsi_pkg::VAL_W-1:0]  res_a_q, res_b_q, lane_a, lane_b;

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      ts_q   <= time_stamp_i;
      va_q   <= value_a_i;
      vb_q   <= value_b_i;
    end
  end

  // Point count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Walking index
  always_comb begin
    unique case (cmd_i.k_op)
      crsi_pkg::K_LOAD_N:  k_d = cnt_q;
      crsi_pkg::K_SET_ONE: k_d = CW'(1);
      crsi_pkg::K_INC:     k_d = k_q + CW'(1);
      crsi_pkg::K_DEC:     k_d = k_q - CW'(1);
      default:             k_d = k_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
  end

  // Read address select
  assign last_idx = cnt_q - CW'(1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      crsi_pkg::RD_ZERO: rd_idx = '0;
      crsi_pkg::RD_LAST: rd_idx = last_idx;
      crsi_pkg::RD_K:    rd_idx = k_q;
      crsi_pkg::RD_KP1:  rd_idx = k_q + CW'(1);
      crsi_pkg::RD_KM2:  rd_idx = k_q - CW'(2);
      default:           rd_idx = '0;
    endcase
  end

  assign raddr = rd_idx[AW-1:0];
  assign new_e = '{tstamp: ts_q, val_a: va_q, val_b: vb_q};
  assign wr_e  = cmd_i.wr_new ? new_e : rd_e;

  crsi_ram #(
    .WIDTH (crsi_pkg::ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (k_q[AW-1:0]),
    .wdata_i (wr_e),
    .raddr_i (raddr),
    .rdata_o (rd_e)
  );

  // Segment window: p0 = prev2, p1 = prev, p2 = cur, p3 = neighbor
  always_ff @(posedge clk_i) begin
    if (cmd_i.win_init) begin
      prev2_q <= rd_e;
      prev_q  <= rd_e;
    end else if (cmd_i.win_shift) begin
      prev2_q <= prev_q;
      prev_q  <= rd_e;
    end
    if (cmd_i.cap_seg) begin
      cur_q <= rd_e;
    end
    if (cmd_i.cap_seg || cmd_i.cap_p3) begin
      p3_q <= rd_e;
    end
  end

  // Restoring divider: t = offset * 2^16 / span, one quotient bit a cycle
  assign span    = cur_q.tstamp - prev_q.tstamp;
  assign q_bit   = (rem_q >= {1'b0, span});
  assign rem_sub = q_bit ? (rem_q - {1'b0, span}) : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_seg) begin
      rem_q <= {1'b0, ts_q - prev_q.tstamp};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= {rem_sub[TW-1:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
  end

  assign t_val = (span == '0) ? '0 : quo_q;

  // Spline lanes
  crsi_cubic u_lane_a (
    .clk_i      (clk_i),
    .op_i       (cmd_i.lane_op),
    .coef_sel_i (cmd_i.coef_sel),
    .p0_i       (prev2_q.val_a),
    .p1_i       (prev_q.val_a),
    .p2_i       (cur_q.val_a),
    .p3_i       (p3_q.val_a),
    .t_i        (t_val),
    .res_o      (lane_a)
  );

  crsi_cubic u_lane_b (
    .clk_i      (clk_i),
    .op_i       (cmd_i.lane_op),
    .coef_sel_i (cmd_i.coef_sel),
    .p0_i       (prev2_q.val_b),
    .p1_i       (prev_q.val_b),
    .p2_i       (cur_q.val_b),
    .p3_i       (p3_q.val_b),
    .t_i        (t_val),
    .res_o      (lane_b)
  );

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q <= cmd_i.fin_status;
      echo_q   <= ts_q;
      res_a_q  <= (cmd_i.fin_status == crsi_pkg::ST_INTERP) ? lane_a : '0;
      res_b_q  <= (cmd_i.fin_status == crsi_pkg::ST_INTERP) ? lane_b : '0;
    end
  end

  assign status_o    = status_q;
  assign echo_time_o = echo_q;
  assign result_a_o  = res_a_q;
  assign result_b_o  = res_b_q;

  // Status to the controller
  assign stat_o.mode     = mode_q;
  assign stat_o.cnt_full = (cnt_q >= CW'(MAX_POINTS));
  assign stat_o.cnt_zero = (cnt_q == '0);
  assign stat_o.cnt_lt2  = (cnt_q < CW'(2));
  assign stat_o.k_one    = (k_q == CW'(1));
  assign stat_o.k_last   = (k_q == last_idx);
  assign stat_o.rd_gt    = (rd_e.tstamp > ts_q);
  assign stat_o.rd_lt    = (rd_e.tstamp < ts_q);

  // Point count stays within the table
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_POINTS))
    else $error("point count beyond table depth");

endmodule

// ===== design/catmull_rom_series_interpolator.sv =====
// Top level of the Catmull-Rom series interpolator.
// Depends on crsi_pkg, crsi_ctrl and crsi_dp.
//
// Usage: drive mode_i, time_stamp_i, value_a_i, value_b_i and raise start_i;
// the request is taken at a clock edge where start_i is high and busy_o low.
// Mode 0 clears the table, mode 1 loads a point in time order, mode 2 or 3
// queries both series at time_stamp_i. Every request gives one result, shown
// on status_o, echo_time_o, result_a_o and result_b_o for exactly one cycle
// with done_o high. The receiver cannot stall; the result must be taken then.
// busy_o falls in the cycle the result shows, so a new request can be taken
// while the result is on the ports.
// Clear, a full table and too few points finish in the decode state; a
// load first moves each stored point later than the new one up by one
// slot, then writes the new point; a query checks both table ends, scans
// for the segment, divides and runs the spline steps. The table's single
// read port paces insert and search, one entry a cycle; the divider yields one quotient bit a cycle.
// Reset empties the table (point count zero); the table storage itself is
// not cleared and needs no sweep.
module catmull_rom_series_interpolator #(
  parameter int unsigned MAX_POINTS = crsi_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [crsi_pkg::MODE_W-1:0] mode_i,
  input  logic [crsi_pkg::TIME_W-1:0] time_stamp_i,
  input  logic [crsi_pkg::VAL_W-1:0]  value_a_i,
  input  logic [crsi_pkg::VAL_W-1:0]  value_b_i,
  output logic                        done_o,
  output logic [crsi_pkg::STAT_W-1:0] status_o,
  output logic [crsi_pkg::TIME_W-1:0] echo_time_o,
  output logic [crsi_pkg::VAL_W-1:0]  result_a_o,
  output logic [crsi_pkg::VAL_W-1:0]  result_b_o
);

  crsi_pkg::cmd_t  cmd;
  crsi_pkg::stat_t stat;

  crsi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  crsi_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (mode_i),
    .time_stamp_i (time_stamp_i),
    .value_a_i    (value_a_i),
    .value_b_i    (value_b_i),
    .status_o     (status_o),
    .echo_time_o  (echo_time_o),
    .result_a_o   (result_a_o),
    .result_b_o   (result_b_o)
  );

endmodule
